// ===== rtl/hash_multimap_chained_defines.svh =====
// ----------------------------------------------------------------------------
// hash_multimap_chained_defines
// assertion macros for the hash multimap rtl
// ----------------------------------------------------------------------------
`ifndef HASH_MULTIMAP_CHAINED_DEFINES_SVH
`define HASH_MULTIMAP_CHAINED_DEFINES_SVH

// same-cycle implication
`define HMC_ASSERT_IMP(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define HMC_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/hmc_pkg.sv =====
// ----------------------------------------------------------------------------
// hmc_pkg
// types, sizes and codes of the chained hash multimap
// ----------------------------------------------------------------------------
package hmc_pkg;

	localparam int NUM_BUCKETS = 256;
	localparam int KEY_SLOTS   = 1024;
	localparam int DATA_SLOTS  = 4096;

	localparam int KEY_W     = 32;
	localparam int HANDLE_W  = 32;
	localparam int CFG_W     = 9;
	localparam int OUT_CNT_W = 13;
	localparam int CNT_SAT   = 2 ** OUT_CNT_W - 1;

	localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = CFG_W'(251);

	localparam int BW  = $clog2(NUM_BUCKETS);
	localparam int MW  = $clog2(NUM_BUCKETS + 1);
	localparam int KW  = $clog2(KEY_SLOTS);
	localparam int HW  = $clog2(DATA_SLOTS);
	localparam int KLW = $clog2(KEY_SLOTS + 1);
	localparam int HLW = $clog2(DATA_SLOTS + 1);
	localparam int CW  = $clog2(DATA_SLOTS + 1);
	localparam int DCW = $clog2(KEY_W + 1);

	typedef logic [KLW-1:0] klink_t;
	typedef logic [HLW-1:0] hlink_t;
	typedef logic [CW-1:0]  cnt_t;

	localparam klink_t KEY_NIL    = KLW'(KEY_SLOTS);
	localparam hlink_t HANDLE_NIL = HLW'(DATA_SLOTS);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_KEY_ABSENT    = 2'd1,
		ST_HANDLE_ABSENT = 2'd2,
		ST_POOL_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]          operation;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} in_t;

	typedef struct packed {
		status_t              status;
		logic                 key_present;
		logic [OUT_CNT_W-1:0] handle_count;
	} out_t;

	typedef struct packed {
		logic [KEY_W-1:0] value;
		klink_t           next;
		hlink_t           list_head;
		cnt_t             cnt;
	} key_ent_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] value;
		hlink_t              next;
	} hdl_ent_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_BKT,
		S_KCHK,
		S_KRD,
		S_DISP,
		S_HCHK,
		S_HRD,
		S_WR1,
		S_WR2,
		S_DONE
	} fsm_t;

	function automatic logic [OUT_CNT_W-1:0] sat_cnt(input cnt_t c);
		if (32'(c) > CNT_SAT)
			return OUT_CNT_W'(CNT_SAT);
		return OUT_CNT_W'(c);
	endfunction

endpackage

// ===== rtl/hmc_ram.sv =====
// ----------------------------------------------------------------------------
// hmc_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module hmc_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/hmc_div.sv =====
// ----------------------------------------------------------------------------
// hmc_div
// restoring remainder unit, one key bit per cycle
// ----------------------------------------------------------------------------
module hmc_div import hmc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] dividend,
	input  logic [MW-1:0]    divisor,
	output logic             done,
	output logic [BW-1:0]    rem
);

	logic [KEY_W-1:0] dvd_q;
	logic [MW-1:0]    dvs_q;
	logic [MW-1:0]    r_q;
	logic [DCW-1:0]   cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [MW:0]      t;
	logic [MW:0]      d;
	logic [MW-1:0]    nr;

	always_comb begin
		t  = {r_q, dvd_q[KEY_W-1]};
		d  = {1'b0, dvs_q};
		nr = (t >= d) ? MW'(t - d) : MW'(t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= DCW'(cnt_q + 1'b1);
			if (cnt_q == DCW'(KEY_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			r_q   <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			r_q   <= nr;
		end
	end

	assign done = done_q;
	assign rem  = r_q[BW-1:0];

endmodule

// ===== rtl/hmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// hmc_ctrl
// sequencer: chain walks, free-slot stacks and read-modify-write of the pools
// ----------------------------------------------------------------------------
module hmc_ctrl import hmc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [MW-1:0] modulus,
	input  logic          in_valid,
	output logic          in_stall,
	input  in_t           in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output out_t          out_data
);

	fsm_t state_q, state_d;

	in_t      req_q;
	logic [BW-1:0] b_q;
	logic [NUM_BUCKETS-1:0] bv_q;
	klink_t   cur_q, prev_q;
	key_ent_t pent_q, kent_q;
	logic [KW-1:0] k_q, ks_q;
	logic     found_q;
	hlink_t   hc_q, hp_q;
	hdl_ent_t hpent_q, hd_q;
	logic [HW-1:0] hs_q;
	out_t     res_q, out_q;
	logic     out_valid_q;
	klink_t   khwm_q, ksp_q;
	hlink_t   hhwm_q, hsp_q;

	logic          div_start, div_done;
	logic [BW-1:0] div_rem;

	logic     bk_we;
	klink_t   bk_wd, bk_rd;
	logic     kr_we;
	logic [KW-1:0] kr_wa;
	key_ent_t kr_wd, kr_rd;
	logic     hr_we;
	logic [HW-1:0] hr_wa;
	hdl_ent_t hr_wd, hd_rd;
	logic     kpush, hpush, kpop, hpop;
	logic [KW-1:0] kst_rd, ks_sel;
	logic [HW-1:0] hst_rd, hs_sel;
	logic     kavail, havail, ins_ok, last, leave;

	hmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_data.key),
		.divisor  (modulus),
		.done     (div_done),
		.rem      (div_rem)
	);

	hmc_ram #(.DEPTH(NUM_BUCKETS), .WIDTH(KLW)) u_bucket (
		.clk(clk), .we(bk_we), .waddr(b_q), .wdata(bk_wd),
		.raddr(div_rem), .rdata(bk_rd)
	);

	hmc_ram #(.DEPTH(KEY_SLOTS), .WIDTH($bits(key_ent_t))) u_key (
		.clk(clk), .we(kr_we), .waddr(kr_wa), .wdata(kr_wd),
		.raddr(cur_q[KW-1:0]), .rdata(kr_rd)
	);

	hmc_ram #(.DEPTH(DATA_SLOTS), .WIDTH($bits(hdl_ent_t))) u_handle (
		.clk(clk), .we(hr_we), .waddr(hr_wa), .wdata(hr_wd),
		.raddr(hc_q[HW-1:0]), .rdata(hd_rd)
	);

	hmc_ram #(.DEPTH(KEY_SLOTS), .WIDTH(KW)) u_kfree (
		.clk(clk), .we(kpush), .waddr(ksp_q[KW-1:0]), .wdata(k_q),
		.raddr(KW'(ksp_q - 1'b1)), .rdata(kst_rd)
	);

	hmc_ram #(.DEPTH(DATA_SLOTS), .WIDTH(HW)) u_hfree (
		.clk(clk), .we(hpush), .waddr(hsp_q[HW-1:0]), .wdata(hc_q[HW-1:0]),
		.raddr(HW'(hsp_q - 1'b1)), .rdata(hst_rd)
	);

	// slot allocation and unlink conditions
	always_comb begin
		kavail = (ksp_q != '0) || (khwm_q != KEY_NIL);
		havail = (hsp_q != '0) || (hhwm_q != HANDLE_NIL);
		ks_sel = (ksp_q != '0) ? kst_rd : khwm_q[KW-1:0];
		hs_sel = (hsp_q != '0) ? hst_rd : hhwm_q[HW-1:0];
		ins_ok = found_q ? havail : (kavail && havail);
		last   = (hp_q == HANDLE_NIL) && (hd_q.next == HANDLE_NIL);
		leave  = !out_valid_q || !out_stall;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_DIV;
			S_DIV:  if (div_done) state_d = S_BKT;
			S_BKT:  state_d = S_KCHK;
			S_KCHK: state_d = (cur_q == KEY_NIL) ? S_DISP : S_KRD;
			S_KRD:  state_d = (kr_rd.value == req_q.key) ? S_DISP : S_KCHK;
			S_DISP: begin
				case (req_q.operation)
					OP_INSERT: state_d = ins_ok ? S_WR1 : S_DONE;
					OP_REMOVE: state_d = found_q ? S_HCHK : S_DONE;
					default:   state_d = S_DONE;
				endcase
			end
			S_HCHK: state_d = (hc_q == HANDLE_NIL) ? S_DONE : S_HRD;
			S_HRD:  state_d = (hd_rd.value == req_q.handle) ? S_WR1 : S_HCHK;
			S_WR1:  state_d = (req_q.operation == OP_INSERT && !found_q) ? S_WR2 : S_DONE;
			S_WR2:  state_d = S_DONE;
			S_DONE: if (leave) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory writes and stack moves
	always_comb begin
		div_start = 1'b0;
		bk_we = 1'b0;
		bk_wd = KEY_NIL;
		kr_we = 1'b0;
		kr_wa = k_q;
		kr_wd = kent_q;
		hr_we = 1'b0;
		hr_wa = hs_q;
		hr_wd = hd_q;
		kpush = 1'b0;
		hpush = 1'b0;
		kpop  = 1'b0;
		hpop  = 1'b0;
		case (state_q)
			S_IDLE: div_start = in_valid;
			S_DISP: begin
				if (req_q.operation == OP_INSERT && ins_ok) begin
					hpop = 1'b1;
					kpop = !found_q;
				end
			end
			S_WR1: begin
				if (req_q.operation == OP_INSERT) begin
					hr_we = 1'b1;
					hr_wa = hs_q;
					hr_wd.value = req_q.handle;
					hr_wd.next  = found_q ? kent_q.list_head : HANDLE_NIL;
					kr_we = 1'b1;
					if (found_q) begin
						kr_wa = k_q;
						kr_wd.list_head = HLW'(hs_q);
						kr_wd.cnt = cnt_t'(kent_q.cnt + 1'b1);
					end else begin
						kr_wa = ks_q;
						kr_wd.value = req_q.key;
						kr_wd.next = KEY_NIL;
						kr_wd.list_head = HLW'(hs_q);
						kr_wd.cnt = cnt_t'(1);
					end
				end else begin
					hpush = 1'b1;
					if (hp_q != HANDLE_NIL) begin
						hr_we = 1'b1;
						hr_wa = hp_q[HW-1:0];
						hr_wd.value = hpent_q.value;
						hr_wd.next  = hd_q.next;
					end
					if (last) begin
						kpush = 1'b1;
						if (prev_q == KEY_NIL) begin
							bk_we = 1'b1;
							bk_wd = kent_q.next;
						end else begin
							kr_we = 1'b1;
							kr_wa = prev_q[KW-1:0];
							kr_wd = pent_q;
							kr_wd.next = kent_q.next;
						end
					end else begin
						kr_we = 1'b1;
						kr_wa = k_q;
						if (hp_q == HANDLE_NIL)
							kr_wd.list_head = hd_q.next;
						kr_wd.cnt = cnt_t'(kent_q.cnt - 1'b1);
					end
				end
			end
			S_WR2: begin
				// link the new key at the chain tail
				if (prev_q == KEY_NIL) begin
					bk_we = 1'b1;
					bk_wd = KLW'(ks_q);
				end else begin
					kr_we = 1'b1;
					kr_wa = prev_q[KW-1:0];
					kr_wd = pent_q;
					kr_wd.next = KLW'(ks_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bv_q        <= '0;
			khwm_q      <= '0;
			ksp_q       <= '0;
			hhwm_q      <= '0;
			hsp_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (bk_we)
				bv_q[b_q] <= 1'b1;
			if (kpush)
				ksp_q <= KLW'(ksp_q + 1'b1);
			else if (kpop && ksp_q != '0)
				ksp_q <= KLW'(ksp_q - 1'b1);
			else if (kpop)
				khwm_q <= KLW'(khwm_q + 1'b1);
			if (hpush)
				hsp_q <= HLW'(hsp_q + 1'b1);
			else if (hpop && hsp_q != '0)
				hsp_q <= HLW'(hsp_q - 1'b1);
			else if (hpop)
				hhwm_q <= HLW'(hhwm_q + 1'b1);
			if (state_q == S_DONE && leave)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_valid) req_q <= in_data;
			S_DIV:  if (div_done) b_q <= div_rem;
			S_BKT: begin
				cur_q   <= bv_q[b_q] ? bk_rd : KEY_NIL;
				prev_q  <= KEY_NIL;
				found_q <= 1'b0;
			end
			S_KRD: begin
				if (kr_rd.value == req_q.key) begin
					found_q <= 1'b1;
					k_q     <= cur_q[KW-1:0];
					kent_q  <= kr_rd;
				end else begin
					prev_q <= cur_q;
					pent_q <= kr_rd;
					cur_q  <= kr_rd.next;
				end
			end
			S_DISP: begin
				case (req_q.operation)
					OP_INSERT: begin
						hs_q <= hs_sel;
						ks_q <= ks_sel;
						res_q <= '{ST_POOL_FULL, found_q,
							found_q ? sat_cnt(kent_q.cnt) : '0};
					end
					OP_REMOVE: begin
						hc_q  <= kent_q.list_head;
						hp_q  <= HANDLE_NIL;
						res_q <= '{ST_KEY_ABSENT, 1'b0, '0};
					end
					default: begin
						if (found_q)
							res_q <= '{ST_OK, 1'b1, sat_cnt(kent_q.cnt)};
						else
							res_q <= '{ST_KEY_ABSENT, 1'b0, '0};
					end
				endcase
			end
			S_HCHK: res_q <= '{ST_HANDLE_ABSENT, 1'b1, sat_cnt(kent_q.cnt)};
			S_HRD: begin
				if (hd_rd.value == req_q.handle) begin
					hd_q <= hd_rd;
				end else begin
					hp_q    <= hc_q;
					hpent_q <= hd_rd;
					hc_q    <= hd_rd.next;
				end
			end
			S_WR1: begin
				if (req_q.operation == OP_INSERT)
					res_q <= '{ST_OK, 1'b1,
						found_q ? sat_cnt(cnt_t'(kent_q.cnt + 1'b1)) : sat_cnt(cnt_t'(1))};
				else if (last)
					res_q <= '{ST_OK, 1'b0, '0};
				else
					res_q <= '{ST_OK, 1'b1, sat_cnt(cnt_t'(kent_q.cnt - 1'b1))};
			end
			S_DONE: if (leave) out_q <= res_q;
			default: ;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/hash_multimap_chained.sv =====
// ----------------------------------------------------------------------------
// hash_multimap_chained
// chained hash multimap over key and handle node pools
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_stall     in_data   (operation, key, handle)
//   out       output     out_valid / out_stall   out_data  (status, present, count)
//   cfg       input      cfg_we                  cfg_data  (bucket_count)
//
// one item at a time: accept, key remainder, bucket read, then per key visited in
//   the chain a check and a ram read, a last check when the chain ends without a
//   match, dispatch, per handle visited on remove a check and a ram read, a last
//   check when the list ends without a match, write-back in S_WR1 and, for a new
//   key, S_WR2 when the operation goes ahead, and the result.
// asynchronous reset leaves all buckets empty and both pools free, no sweep
// a finished result waits in the output register while out_stall is high
// ----------------------------------------------------------------------------
`include "hash_multimap_chained_defines.svh"

module hash_multimap_chained import hmc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_t             out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] bucket_count_q;
	logic [31:0]      bc32;
	logic [MW-1:0]    modulus;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bucket_count_q <= BUCKET_COUNT_RST;
		else if (cfg_we)
			bucket_count_q <= cfg_data;
	end

	// clamp the modulus to 1 .. NUM_BUCKETS
	always_comb begin
		bc32 = 32'(bucket_count_q);
		if (bc32 == 32'd0)
			modulus = MW'(1);
		else if (bc32 > NUM_BUCKETS)
			modulus = MW'(NUM_BUCKETS);
		else
			modulus = MW'(bc32);
	end

	hmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.modulus   (modulus),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`HMC_ASSERT_IMP(a_present_count, out_valid && out_data.key_present, out_data.handle_count != '0, "present key with zero handles")
	`HMC_ASSERT_IMP(a_absent_count, out_valid && !out_data.key_present, out_data.handle_count == '0, "absent key with handles")
	`HMC_ASSERT_IMP(a_absent_status, out_valid && out_data.status == ST_KEY_ABSENT, !out_data.key_present, "key absent but present")
	`HMC_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "second transfer during work")

endmodule
